@@ src/sdcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Spring-dashpot contact force package
// Shared widths, register indexes and the beat records of the long
// divider and square-root stages.
// ----------------------------------------------------------------------------
package sdcf_pkg;

  localparam int NORM_W     = 16;  // normal component width
  localparam int NORM_FRAC  = 14;  // fraction bits of the normal
  localparam int VEL_W      = 32;
  localparam int MASS_W     = 32;
  localparam int FORCE_W    = 64;
  localparam int K_W        = 48;  // stiffness register width
  localparam int R_W        = 24;  // damping ratio register width
  localparam int K_HALF     = K_W / 2;
  localparam int VN_W       = 37;  // normal velocity width after the shift
  localparam int DIV_STEPS  = 32;  // quotient bits of the reduced mass
  localparam int SQRT_STEPS = 40;  // root bits of sqrt(k * m)
  localparam int KM_W       = 2 * SQRT_STEPS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = K_W;

  // Stiffness reset value in whole units, scaled by the fraction bits.
  localparam longint unsigned K_RESET_INT = 64'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd1;

  // Per-contact data that rides along with the long arithmetic.
  typedef struct packed {
    logic [NORM_W-1:0] n_x;
    logic [NORM_W-1:0] n_y;
    logic [NORM_W-1:0] n_z;
    logic [VN_W-1:0]   vn;
    logic [VEL_W-1:0]  depth;
  } side_t;

  typedef struct packed {
    logic [MASS_W:0]   rem;    // partial remainder, below msum
    logic [MASS_W-1:0] pl;     // low product bits still to shift in
    logic [MASS_W-1:0] q;      // quotient so far
    logic [MASS_W:0]   msum;
    logic              mzero;
    side_t             side;
  } div_st_t;

  typedef struct packed {
    logic [KM_W-1:0]       rem;   // radicand minus root squared
    logic [SQRT_STEPS-1:0] root;
    side_t                 side;
  } sq_st_t;

endpackage

@@ src/spring_dashpot_contact_force.sv @@
// ----------------------------------------------------------------------------
// Spring-dashpot contact force
// Linear spring-dashpot normal contact force, one contact per beat.
// ----------------------------------------------------------------------------
// The block takes one contact per clock beat and returns one force vector per
// contact, in order. A contact enters in every cycle in which the output
// side is not stalled. The pipeline depth is the same for any FRAC_BITS value;
// it is set by the two bit-serial units laid out in stages: the reduced
// mass mi*mj/(mi+mj) is a 32-stage restoring divider, one quotient bit per
// stage, and sqrt(k*m) is a 40-stage square root, one root bit per stage.
// The rest is three input stages (velocity difference and mass product, dot
// product terms, dot sum) and nine multiply and add stages where every wide
// product is split into partial products of at most about 32 bits.
// All stages advance together on one enable, so a stall at the output freezes
// the whole pipeline and no beat is lost or repeated. The stiffness and the
// damping ratio registers are read straight by the arithmetic and may only be
// written while no contact is in flight. Fractions are dropped by rounding
// toward minus infinity and each force component saturates to 64 bits.
module spring_dashpot_contact_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sdcf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sdcf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sdcf_pkg::NORM_W-1:0] normal_x_i,
  input  logic signed [sdcf_pkg::NORM_W-1:0] normal_y_i,
  input  logic signed [sdcf_pkg::NORM_W-1:0] normal_z_i,
  input  logic signed [sdcf_pkg::VEL_W-1:0]  vel_i_x_i,
  input  logic signed [sdcf_pkg::VEL_W-1:0]  vel_i_y_i,
  input  logic signed [sdcf_pkg::VEL_W-1:0]  vel_i_z_i,
  input  logic signed [sdcf_pkg::VEL_W-1:0]  vel_j_x_i,
  input  logic signed [sdcf_pkg::VEL_W-1:0]  vel_j_y_i,
  input  logic signed [sdcf_pkg::VEL_W-1:0]  vel_j_z_i,
  input  logic signed [sdcf_pkg::VEL_W-1:0]  depth_i,
  input  logic [sdcf_pkg::MASS_W-1:0]        mass_i_i,
  input  logic [sdcf_pkg::MASS_W-1:0]        mass_j_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sdcf_pkg::FORCE_W-1:0] force_x_o,
  output logic signed [sdcf_pkg::FORCE_W-1:0] force_y_o,
  output logic signed [sdcf_pkg::FORCE_W-1:0] force_z_o
);
  import sdcf_pkg::*;

  // Width bookkeeping. Everything that depends on the fraction bits follows
  // from FRAC_BITS here.
  localparam logic [K_W-1:0] K_RST = K_W'(K_RESET_INT << FRAC_BITS);
  localparam logic [R_W-1:0] R_RST = R_W'(64'd1 << FRAC_BITS);
  localparam int CW    = 65 - FRAC_BITS;          // damping coefficient width
  localparam int CL    = CW / 2;
  localparam int CH    = CW - CL;
  localparam int KD_W  = K_W + VEL_W + 1;         // k * depth
  localparam int CV_W  = CW + VN_W + 1;           // c * vn
  localparam int SUM_W = ((KD_W > CV_W) ? KD_W : CV_W) + 1;
  localparam int FN_W  = SUM_W - FRAC_BITS;       // force magnitude
  localparam int FL    = FN_W / 2;
  localparam int FH    = FN_W - FL;
  localparam int PW    = FN_W + NORM_W + 1;       // magnitude times normal
  localparam int SH_W  = ((PW - NORM_FRAC) > FORCE_W) ? (PW - NORM_FRAC) : FORCE_W + 1;
  localparam int PE_W  = SH_W + NORM_FRAC;

  // Configuration registers.
  logic [K_W-1:0] k_q;
  logic [R_W-1:0] ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= K_RST;
      ratio_q <= R_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STIFFNESS: k_q     <= cfg_wdata_i[K_W-1:0];
        CFG_RATIO:     ratio_q <= cfg_wdata_i[R_W-1:0];
        default: ;
      endcase
    end
  end

  // One enable for the whole pipe: it moves whenever the output register is
  // empty or is being drained in this cycle.
  logic en;
  logic out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // Stage A: velocity difference, mass product and mass sum.
  logic                     a_v_q;
  logic signed [NORM_W-1:0] a_n_q [3];
  logic signed [VEL_W:0]    a_vij_q [3];
  logic [VEL_W-1:0]         a_depth_q;
  logic [2*MASS_W-1:0]      a_p_q;
  logic [MASS_W:0]          a_msum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_n_q[0]   <= normal_x_i;
      a_n_q[1]   <= normal_y_i;
      a_n_q[2]   <= normal_z_i;
      a_vij_q[0] <= (VEL_W+1)'(vel_j_x_i) - (VEL_W+1)'(vel_i_x_i);
      a_vij_q[1] <= (VEL_W+1)'(vel_j_y_i) - (VEL_W+1)'(vel_i_y_i);
      a_vij_q[2] <= (VEL_W+1)'(vel_j_z_i) - (VEL_W+1)'(vel_i_z_i);
      a_depth_q  <= depth_i;
      a_p_q      <= (2*MASS_W)'(mass_i_i) * (2*MASS_W)'(mass_j_i);
      a_msum_q   <= {1'b0, mass_i_i} + {1'b0, mass_j_i};
    end
  end

  // Stage B: the three dot product terms.
  logic                     b_v_q;
  logic signed [NORM_W-1:0] b_n_q [3];
  logic signed [VEL_W+NORM_W:0] b_dp_q [3];
  logic [VEL_W-1:0]         b_depth_q;
  logic [2*MASS_W-1:0]      b_p_q;
  logic [MASS_W:0]          b_msum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        b_n_q[a]  <= a_n_q[a];
        b_dp_q[a] <= a_vij_q[a] * a_n_q[a];
      end
      b_depth_q <= a_depth_q;
      b_p_q     <= a_p_q;
      b_msum_q  <= a_msum_q;
    end
  end

  // Stage C: dot sum and normal velocity; the divider is loaded with the
  // upper product half, which is already below the mass sum.
  logic signed [VEL_W+NORM_W+2:0] c_dot;
  div_st_t div_q [DIV_STEPS+1];
  logic    div_v_q [DIV_STEPS+1];

  assign c_dot = (VEL_W+NORM_W+3)'(b_dp_q[0]) + (VEL_W+NORM_W+3)'(b_dp_q[1])
               + (VEL_W+NORM_W+3)'(b_dp_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].rem        <= {1'b0, b_p_q[2*MASS_W-1:MASS_W]};
      div_q[0].pl         <= b_p_q[MASS_W-1:0];
      div_q[0].q          <= '0;
      div_q[0].msum       <= b_msum_q;
      div_q[0].mzero      <= (b_msum_q == '0);
      div_q[0].side.n_x   <= b_n_q[0];
      div_q[0].side.n_y   <= b_n_q[1];
      div_q[0].side.n_z   <= b_n_q[2];
      div_q[0].side.vn    <= c_dot[NORM_FRAC+VN_W-1:NORM_FRAC];
      div_q[0].side.depth <= b_depth_q;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [MASS_W+1:0] t;
    logic [MASS_W+2:0] diff;
    logic              ge;
    div_st_t           nxt;

    always_comb begin
      t    = {div_q[j].rem, div_q[j].pl[MASS_W-1]};
      diff = {1'b0, t} - {2'b0, div_q[j].msum};
      ge   = !diff[MASS_W+2];
      nxt      = div_q[j];
      nxt.rem  = ge ? diff[MASS_W:0] : t[MASS_W:0];
      nxt.pl   = {div_q[j].pl[MASS_W-2:0], 1'b0};
      nxt.q    = {div_q[j].q[MASS_W-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[j+1] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[j+1] <= 1'b0;
      end else if (en) begin
        div_v_q[j+1] <= div_v_q[j];
      end
    end
  end

  // Stage M1 and M2: k times the reduced mass, as two partial products.
  logic [MASS_W-1:0]        ma;
  logic                     m1_v_q;
  logic [K_HALF+MASS_W-1:0] m1_lo_q;
  logic [K_HALF+MASS_W-1:0] m1_hi_q;
  side_t                    m1_side_q;
  sq_st_t                   sq_q [SQRT_STEPS+1];
  logic                     sq_v_q [SQRT_STEPS+1];

  assign ma = div_q[DIV_STEPS].mzero ? '0 : div_q[DIV_STEPS].q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_lo_q   <= k_q[K_HALF-1:0] * ma;
      m1_hi_q   <= k_q[K_W-1:K_HALF] * ma;
      m1_side_q <= div_q[DIV_STEPS].side;
      sq_q[0].rem  <= {m1_hi_q, {K_HALF{1'b0}}} + KM_W'(m1_lo_q);
      sq_q[0].root <= '0;
      sq_q[0].side <= m1_side_q;
    end
  end

  // Square root, one root bit per stage. The remainder holds the radicand
  // minus the square of the root found so far.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int BIT = SQRT_STEPS - 1 - j;
    logic [KM_W:0] test;
    logic [KM_W:0] diff;
    logic          ge;
    sq_st_t        nxt;

    always_comb begin
      test = ((KM_W+1)'(sq_q[j].root) << (BIT + 1)) | ((KM_W+1)'(1) << (2 * BIT));
      diff = {1'b0, sq_q[j].rem} - test;
      ge   = !diff[KM_W];
      nxt      = sq_q[j];
      nxt.rem  = ge ? diff[KM_W-1:0] : sq_q[j].rem;
      nxt.root = ge ? (sq_q[j].root | (SQRT_STEPS'(1) << BIT)) : sq_q[j].root;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[j+1] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[j+1] <= sq_v_q[j];
      end
    end
  end

  // Stage R1: ratio * sqrt and k * depth, each as two partial products.
  localparam int SQ_HALF = SQRT_STEPS / 2;
  side_t                           r1_side;
  logic                            r1_v_q;
  logic [R_W+SQ_HALF-1:0]          r1_cs_lo_q;
  logic [R_W+SQRT_STEPS-SQ_HALF-1:0] r1_cs_hi_q;
  logic signed [K_HALF+VEL_W:0]    r1_kd_lo_q;
  logic signed [K_W-K_HALF+VEL_W:0] r1_kd_hi_q;
  logic signed [VN_W-1:0]          r1_vn_q;
  logic signed [NORM_W-1:0]        r1_n_q [3];

  assign r1_side = sq_q[SQRT_STEPS].side;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_cs_lo_q <= ratio_q * sq_q[SQRT_STEPS].root[SQ_HALF-1:0];
      r1_cs_hi_q <= ratio_q * sq_q[SQRT_STEPS].root[SQRT_STEPS-1:SQ_HALF];
      r1_kd_lo_q <= $signed({1'b0, k_q[K_HALF-1:0]}) * $signed(r1_side.depth);
      r1_kd_hi_q <= $signed({1'b0, k_q[K_W-1:K_HALF]}) * $signed(r1_side.depth);
      r1_vn_q    <= r1_side.vn;
      r1_n_q[0]  <= r1_side.n_x;
      r1_n_q[1]  <= r1_side.n_y;
      r1_n_q[2]  <= r1_side.n_z;
    end
  end

  // Stage R2: damping coefficient c = 2 * ratio * sqrt, and k * depth.
  logic [63:0]              r2_cs;
  logic                     r2_v_q;
  logic [CW-1:0]            r2_c_q;
  logic signed [KD_W-1:0]   r2_kd_q;
  logic signed [VN_W-1:0]   r2_vn_q;
  logic signed [NORM_W-1:0] r2_n_q [3];

  assign r2_cs = {r1_cs_hi_q, {SQ_HALF{1'b0}}} + 64'(r1_cs_lo_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_c_q  <= r2_cs[63:FRAC_BITS-1];
      r2_kd_q <= (KD_W'(r1_kd_hi_q) <<< K_HALF) + KD_W'(r1_kd_lo_q);
      r2_vn_q <= r1_vn_q;
      r2_n_q  <= r1_n_q;
    end
  end

  // Stage R3: c * vn as two partial products.
  logic                       r3_v_q;
  logic signed [CL+VN_W:0]    r3_cv_lo_q;
  logic signed [CH+VN_W:0]    r3_cv_hi_q;
  logic signed [KD_W-1:0]     r3_kd_q;
  logic signed [NORM_W-1:0]   r3_n_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r3_cv_lo_q <= $signed({1'b0, r2_c_q[CL-1:0]}) * r2_vn_q;
      r3_cv_hi_q <= $signed({1'b0, r2_c_q[CW-1:CL]}) * r2_vn_q;
      r3_kd_q    <= r2_kd_q;
      r3_n_q     <= r2_n_q;
    end
  end

  // Stage R4: assemble c * vn.
  logic                     r4_v_q;
  logic signed [CV_W-1:0]   r4_cv_q;
  logic signed [KD_W-1:0]   r4_kd_q;
  logic signed [NORM_W-1:0] r4_n_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r4_cv_q <= (CV_W'(r3_cv_hi_q) <<< CL) + CV_W'(r3_cv_lo_q);
      r4_kd_q <= r3_kd_q;
      r4_n_q  <= r3_n_q;
    end
  end

  // Stage R5: force magnitude, fraction bits dropped toward minus infinity.
  logic signed [SUM_W-1:0]  r5_sum;
  logic                     r5_v_q;
  logic signed [FN_W-1:0]   r5_fn_q;
  logic signed [NORM_W-1:0] r5_n_q [3];

  assign r5_sum = SUM_W'(r4_kd_q) + SUM_W'(r4_cv_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r5_fn_q <= r5_sum[SUM_W-1:FRAC_BITS];
      r5_n_q  <= r4_n_q;
    end
  end

  // Stage R6: magnitude times each normal component, split in two halves.
  logic                         r6_v_q;
  logic signed [FL+NORM_W:0]    r6_plo_q [3];
  logic signed [FH+NORM_W-1:0]  r6_phi_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        r6_plo_q[a] <= $signed({1'b0, r5_fn_q[FL-1:0]}) * r5_n_q[a];
        r6_phi_q[a] <= $signed(r5_fn_q[FN_W-1:FL]) * r5_n_q[a];
      end
    end
  end

  // Stage R7: assemble, shift out the normal fraction and saturate.
  logic signed [PW-1:0]      prod [3];
  logic signed [PE_W-1:0]    pext [3];
  logic signed [SH_W-1:0]    shf  [3];
  logic [FORCE_W-1:0]        sat  [3];
  logic [FORCE_W-1:0]        force_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = (PW'(r6_phi_q[a]) <<< FL) + PW'(r6_plo_q[a]);
      pext[a] = PE_W'(prod[a]);
      shf[a]  = pext[a][PE_W-1:NORM_FRAC];
      if ((shf[a][SH_W-1:FORCE_W-1] == '0) || (shf[a][SH_W-1:FORCE_W-1] == '1)) begin
        sat[a] = shf[a][FORCE_W-1:0];
      end else if (shf[a][SH_W-1]) begin
        sat[a] = {1'b1, {(FORCE_W-1){1'b0}}};
      end else begin
        sat[a] = {1'b0, {(FORCE_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      force_q <= sat;
    end
  end

  // Valid bits of the fixed stages. The divider and root chains take their
  // first valid bit here, in step with the data loaded into their first stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      div_v_q[0] <= 1'b0;
      m1_v_q     <= 1'b0;
      sq_v_q[0]  <= 1'b0;
      r1_v_q     <= 1'b0;
      r2_v_q     <= 1'b0;
      r3_v_q     <= 1'b0;
      r4_v_q     <= 1'b0;
      r5_v_q     <= 1'b0;
      r6_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else if (en) begin
      a_v_q      <= in_valid_i;
      b_v_q      <= a_v_q;
      div_v_q[0] <= b_v_q;
      m1_v_q     <= div_v_q[DIV_STEPS];
      sq_v_q[0]  <= m1_v_q;
      r1_v_q     <= sq_v_q[SQRT_STEPS];
      r2_v_q     <= r1_v_q;
      r3_v_q     <= r2_v_q;
      r4_v_q     <= r3_v_q;
      r5_v_q     <= r4_v_q;
      r6_v_q     <= r5_v_q;
      out_v_q    <= r6_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign force_x_o   = force_q[0];
  assign force_y_o   = force_q[1];
  assign force_z_o   = force_q[2];

  // The divider never leaves a remainder at or above the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_v_q[DIV_STEPS] && !div_q[DIV_STEPS].mzero)
      |-> (div_q[DIV_STEPS].rem < div_q[DIV_STEPS].msum))
    else $error("reduced mass remainder not below mass sum");

  // The final root is the floor: radicand - root^2 is at most 2 * root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[SQRT_STEPS]
      |-> (sq_q[SQRT_STEPS].rem <= KM_W'({sq_q[SQRT_STEPS].root, 1'b0})))
    else $error("square root is not the floor root");

  // A stall freezes the valid bits inside the pipe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(out_v_q) && $stable(r6_v_q) && $stable(sq_v_q[0]) && $stable(a_v_q)))
    else $error("pipeline moved during a stall");

  // A new result only appears when the last multiply stage held a contact.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(r6_v_q))
    else $error("result valid without a contact behind it");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Contact force block testbench
// Drives contacts through the spring-dashpot force block with random gaps
// and output stalls, predicts each force vector and checks it in order.
// ----------------------------------------------------------------------------
module tb;
  import sdcf_pkg::*;

  localparam int FRAC_BITS = 16;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int HANG_LIMIT = 3000;
  // Drain margin after the last force, a bit over the pipeline latency.
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_MAX = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [K_W-1:0] K_MAX = {K_W{1'b1}};
  localparam logic [R_W-1:0] R_MAX = {R_W{1'b1}};
  localparam logic signed [127:0] FORCE_POS = 128'sh7fff_ffff_ffff_ffff;
  localparam logic signed [127:0] FORCE_NEG = -FORCE_POS - 128'sd1;

  typedef struct {
    logic signed [NORM_W-1:0] n [3];
    logic signed [VEL_W-1:0]  vi [3];
    logic signed [VEL_W-1:0]  vj [3];
    logic signed [VEL_W-1:0]  depth;
    logic [MASS_W-1:0]        mi;
    logic [MASS_W-1:0]        mj;
  } contact_t;

  typedef struct {
    logic signed [FORCE_W-1:0] f [3];
  } force_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [NORM_W-1:0] nx = '0, ny = '0, nz = '0;
  logic signed [VEL_W-1:0] vix = '0, viy = '0, viz = '0;
  logic signed [VEL_W-1:0] vjx = '0, vjy = '0, vjz = '0;
  logic signed [VEL_W-1:0] depth = '0;
  logic [MASS_W-1:0] mass_i = '0, mass_j = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FORCE_W-1:0] fx, fy, fz;

  // Shadow copy of the two configuration registers, as the block holds them.
  logic [K_W-1:0] stiffness_shadow = K_W'(K_RESET_INT << FRAC_BITS);
  logic [R_W-1:0] ratio_shadow = R_W'(64'd1 << FRAC_BITS);

  force_vec_t pending_forces [$];
  int unsigned mismatches = 0;
  int unsigned contacts_sent = 0;
  int unsigned forces_checked = 0;
  int unsigned settings_used = 0;
  bit tx_steady = 1'b0;   // sender offers back to back while set
  bit rx_steady = 1'b0;   // receiver always ready while set
  int rx_hold = 0;        // long receiver stall, counted down per cycle
  int rx_gap = 0;
  int hang_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spring_dashpot_contact_force #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .normal_x_i(nx), .normal_y_i(ny), .normal_z_i(nz),
    .vel_i_x_i(vix), .vel_i_y_i(viy), .vel_i_z_i(viz),
    .vel_j_x_i(vjx), .vel_j_y_i(vjy), .vel_j_z_i(vjz),
    .depth_i(depth), .mass_i_i(mass_i), .mass_j_i(mass_j),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .force_x_o(fx), .force_y_o(fy), .force_z_o(fz)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Exact force of one contact. All intermediate values are kept wide
  // enough that nothing wraps, and every fraction drop floors.
  function automatic force_vec_t contact_force(contact_t c);
    force_vec_t res;
    logic signed [63:0] nn [3];
    logic signed [63:0] vij, dot, vn;
    logic [63:0] msum, ma, root, trial, damp;
    logic [127:0] km;
    logic signed [127:0] k_s, d_s, c_s, vn_s, mag, prod;
    dot = 0;
    for (int a = 0; a < 3; a++) begin
      nn[a] = 64'(c.n[a]);
      vij = 64'(c.vj[a]) - 64'(c.vi[a]);
      dot += vij * nn[a];
    end
    vn = dot >>> NORM_FRAC;
    msum = 64'(c.mi) + 64'(c.mj);
    // Both masses zero: the reduced mass is taken as zero.
    ma = (msum == 0) ? 64'd0 : (64'(c.mi) * 64'(c.mj)) / msum;
    km = 128'(stiffness_shadow) * 128'(ma);
    root = 0;
    for (int b = SQRT_STEPS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= km) root = trial;
    end
    damp = (64'(ratio_shadow) * root) >> (FRAC_BITS - 1);
    k_s = $signed({80'd0, stiffness_shadow});
    d_s = 128'(c.depth);
    c_s = $signed({64'd0, damp});
    vn_s = 128'(vn);
    mag = (k_s * d_s + c_s * vn_s) >>> FRAC_BITS;
    for (int a = 0; a < 3; a++) begin
      prod = (mag * 128'(nn[a])) >>> NORM_FRAC;
      if (prod > FORCE_POS) res.f[a] = FORCE_POS[63:0];
      else if (prod < FORCE_NEG) res.f[a] = FORCE_NEG[63:0];
      else res.f[a] = prod[63:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom();
    if (r < 8) return 32'($signed($urandom_range(0, 8192)) - 4096) <<< $urandom_range(0, 16);
    if (r == 8) return 32'h8000_0000;
    return 32'h7fff_ffff;
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    int r;
    for (int a = 0; a < 3; a++) begin
      // Normals are mostly inside +-1.0; some carry any 16-bit pattern.
      if ($urandom_range(0, 9) < 8) c.n[a] = 16'($signed($urandom_range(0, 32768)) - 16384);
      else c.n[a] = 16'($urandom());
      c.vi[a] = rand_word();
      c.vj[a] = rand_word();
    end
    c.depth = rand_word();
    r = $urandom_range(0, 19);
    c.mi = (r == 0) ? 32'd0 : (r < 8) ? 32'($urandom_range(1, 1 << 20)) : 32'($urandom());
    r = $urandom_range(0, 19);
    c.mj = (r == 0) ? 32'd0 : (r < 8) ? 32'($urandom_range(1, 1 << 20)) : 32'($urandom());
    return c;
  endfunction

  // Offer one contact and return at the edge where it is taken. Valid is
  // only lowered for a gap, so back-to-back beats keep it high.
  task automatic send_contact(contact_t c);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    nx <= c.n[0]; ny <= c.n[1]; nz <= c.n[2];
    vix <= c.vi[0]; viy <= c.vi[1]; viz <= c.vi[2];
    vjx <= c.vj[0]; vjy <= c.vj[1]; vjz <= c.vj[2];
    depth <= c.depth; mass_i <= c.mi; mass_j <= c.mj;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    pending_forces.push_back(contact_force(c));
    contacts_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_forces.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Registers only change with nothing in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STIFFNESS) stiffness_shadow = data[K_W-1:0];
    else if (idx == CFG_RATIO) ratio_shadow = data[R_W-1:0];
  endtask

  task automatic set_params(logic [K_W-1:0] k, logic [R_W-1:0] ratio);
    write_reg(CFG_STIFFNESS, k);
    write_reg(CFG_RATIO, CFG_DATA_W'(ratio));
    settings_used++;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_contact(rand_contact());
  endtask

  // Reset values of the registers, a handful of ordinary contacts.
  task automatic test_reset_values();
    settings_used++;
    send_random(5);
  endtask

  // Field extremes, zero masses, normals outside the unit range, and
  // forces that saturate in both directions.
  task automatic test_extremes();
    contact_t c;
    for (int i = 0; i < 14; i++) begin
      c = rand_contact();
      case (i)
        0: begin c.mi = 0; c.mj = 0; end
        1: begin c.mi = 0; c.mj = 32'hffff_ffff; end
        2: begin c.mi = 32'hffff_ffff; c.mj = 32'hffff_ffff; end
        3: begin c.mi = 1; c.mj = 1; end
        4: begin
          c.n = '{16'sd16384, 16'sd16384, -16'sd16384};
          c.vi = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
          c.vj = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        end
        5: c.n = '{-16'sd16384, -16'sd16384, 16'sd16384};
        6: c.n = '{16'sh7fff, 16'sh8000, 16'sh0000};
        7: begin c.n = '{16'sh8000, 16'sh7fff, 16'shffff}; c.depth = 32'h7fff_ffff; end
        8: c.depth = 32'h8000_0000;
        9: c.depth = 0;
        default: ;
      endcase
      send_contact(c);
    end
    set_params(K_MAX, R_MAX);
    for (int i = 0; i < 4; i++) begin
      c = rand_contact();
      c.depth = (i[0]) ? 32'h7fff_ffff : 32'h8000_0000;
      c.n = '{16'sh7fff, 16'sh8000, 16'sd16384};
      c.mi = 32'hffff_ffff; c.mj = 32'hffff_ffff;
      send_contact(c);
    end
    set_params('0, '0);
    send_random(3);
    // Writes to the unused indexes must change nothing.
    write_reg(CFG_SPARE, {CFG_DATA_W{1'b1}});
    write_reg(CFG_SPARE_HI, {CFG_DATA_W{1'b1}});
    send_random(3);
  endtask

  // A string of register settings, each with random contacts.
  task automatic test_random_settings();
    logic [K_W-1:0] k;
    logic [R_W-1:0] ratio;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin k = K_MAX; ratio = '0; end
        1: begin k = '0; ratio = R_MAX; end
        2: begin k = K_W'(64'd1 << FRAC_BITS); ratio = R_W'(1 << (FRAC_BITS - 1)); end
        default: begin
          k = {16'($urandom()), 32'($urandom())} >> $urandom_range(0, 40);
          ratio = 24'($urandom()) >> $urandom_range(0, 20);
        end
      endcase
      set_params(k, ratio);
      rx_steady = (s == 3);
      tx_steady = (s == 3);
      send_random(35);
    end
    rx_steady = 1'b0;
    tx_steady = 1'b0;
  endtask

  // The receiver holds off long enough to fill the pipeline while the
  // sender keeps offering back to back, so the input must stall.
  task automatic test_output_stall();
    wait_drained();
    rx_hold = 300;
    tx_steady = 1'b1;
    send_random(120);
    tx_steady = 1'b0;
    while (rx_hold > 0) @(posedge clk);
  endtask

  // The sender stops until every force is back, then resumes.
  task automatic test_sender_pause();
    send_random(20);
    wait_drained();
    send_random(20);
  endtask

  // Receiver: random ready, a long hold when asked, or always ready.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  // Results are compared at the falling edge before the edge that takes the
  // beat, so nothing hinges on event order.
  always @(negedge clk) begin
    force_vec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("tb: force beat with nothing expected: %0d %0d %0d", fx, fy, fz);
      end else begin
        want = pending_forces.pop_front();
        forces_checked++;
        if (want.f[0] !== fx || want.f[1] !== fy || want.f[2] !== fz) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("tb: force %0d expected %0d %0d %0d, got %0d %0d %0d",
                     forces_checked, want.f[0], want.f[1], want.f[2], fx, fy, fz);
        end
      end
    end
  end

  // Watchdog: a run that stops moving beats is a failure.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) hang_count = 0;
      else hang_count++;
      if (hang_count >= HANG_LIMIT) begin
        $display("tb: hang with %0d forces outstanding", pending_forces.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_random_settings();
    test_output_stall();
    test_sender_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d contacts sent, %0d forces checked over %0d register settings",
             contacts_sent, forces_checked, settings_used);
    $display("tb: covered zero masses, off-unit normals, saturation and a full stall");
    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches, %0d forces missing", mismatches, pending_forces.size());
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sdcf_pkg.sv
src/spring_dashpot_contact_force.sv
bench/tb.sv
